// ----- hdl/label_affine_mean_displacement_macros.svh -----
// Assertion helpers for the label affine mean displacement block.
`ifndef LABEL_AFFINE_MEAN_DISPLACEMENT_MACROS_SVH
`define LABEL_AFFINE_MEAN_DISPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define LAMD_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lamd: same-cycle check failed");
`define LAMD_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lamd: next-cycle check failed");
`else
`define LAMD_ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define LAMD_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/lamd_pkg.sv -----
package lamd_pkg;

  localparam int LABEL_W    = 8;
  localparam int COEF_W     = 32;
  localparam int WORD_W     = 64;
  localparam int ROW_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int DIST_W     = 32;
  localparam int SUM_W      = 56;
  localparam int CNT_W      = 25;
  localparam int DIV_CNT_W  = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_LO  = 3'd0,
    REG_ROW0_HI  = 3'd1,
    REG_ROW1_LO  = 3'd2,
    REG_ROW1_HI  = 3'd3,
    REG_ROW2_LO  = 3'd4,
    REG_ROW2_HI  = 3'd5,
    REG_TARGET   = 3'd6
  } cfg_reg_t;

  typedef logic [ROW_REGS-1:0][WORD_W-1:0] coef_bank_t;

  // one request handed from the front to the back
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              matched;
    logic              last;
  } lamd_item_t;

  typedef struct packed {
    logic div_busy;
    logic pop_last;
  } lamd_back_stat_t;

endpackage

// ----- hdl/lamd_front.sv -----
module lamd_front #(
  parameter int COORD_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lamd_pkg::coef_bank_t         coef,
  input  logic [lamd_pkg::LABEL_W-1:0] target_label,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [lamd_pkg::LABEL_W-1:0] in_voxel_value,
  input  logic [COORD_BITS-1:0]        in_coord_x,
  input  logic [COORD_BITS-1:0]        in_coord_y,
  input  logic [COORD_BITS-1:0]        in_coord_z,
  input  logic                         in_last_voxel,
  input  logic                         q_full,
  output logic                         q_wr,
  output lamd_pkg::lamd_item_t         q_item
);
  import lamd_pkg::*;

  localparam int PRW = COEF_W + COORD_BITS + 1;
  localparam int PW  = PRW + 2;
  localparam int DW  = PW + 1;
  localparam int SQW = 2 * DIST_W;
  localparam int RW  = DIST_W + 4;
  localparam int NST = DIST_W;

  logic en;
  logic acc;
  assign en      = !q_full;
  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  // stage 1: capture
  logic                  s1_v_r, s1_m_r, s1_l_r;
  logic [COORD_BITS-1:0] s1_c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc && ((in_voxel_value == target_label) || in_last_voxel);
    end
    if (en) begin
      s1_m_r    <= in_voxel_value == target_label;
      s1_l_r    <= in_last_voxel;
      s1_c_r[0] <= in_coord_x;
      s1_c_r[1] <= in_coord_y;
      s1_c_r[2] <= in_coord_z;
    end
  end

  // stage 2: products
  logic                  s2_v_r, s2_m_r, s2_l_r;
  logic [COORD_BITS-1:0] s2_c_r [3];
  logic [PRW-1:0]        s2_p_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
    if (en) begin
      s2_m_r <= s1_m_r;
      s2_l_r <= s1_l_r;
      for (int i = 0; i < 3; i++) begin
        s2_c_r[i]    <= s1_c_r[i];
        s2_p_r[i][0] <= $signed(coef[2*i][COEF_W-1:0]) * $signed({1'b0, s1_c_r[0]});
        s2_p_r[i][1] <= $signed(coef[2*i][WORD_W-1:COEF_W]) * $signed({1'b0, s1_c_r[1]});
        s2_p_r[i][2] <= $signed(coef[2*i+1][COEF_W-1:0]) * $signed({1'b0, s1_c_r[2]});
        s2_p_r[i][3] <= {{(PRW-COEF_W){coef[2*i+1][WORD_W-1]}},
                         coef[2*i+1][WORD_W-1:COEF_W]};
      end
    end
  end

  // stage 3: displacement magnitude per axis
  logic [PW-1:0]     psum [3];
  logic [DW-1:0]     dval [3];
  logic [DW-1:0]     dmag [3];
  logic [2:0]        dovf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = {{2{s2_p_r[i][0][PRW-1]}}, s2_p_r[i][0]}
              + {{2{s2_p_r[i][1][PRW-1]}}, s2_p_r[i][1]}
              + {{2{s2_p_r[i][2][PRW-1]}}, s2_p_r[i][2]}
              + {{2{s2_p_r[i][3][PRW-1]}}, s2_p_r[i][3]};
      dval[i] = {{(DW-COORD_BITS-FRAC_BITS){1'b0}}, s2_c_r[i], {FRAC_BITS{1'b0}}}
              - {psum[i][PW-1], psum[i]};
      dmag[i] = dval[i][DW-1] ? (~dval[i] + {{(DW-1){1'b0}}, 1'b1}) : dval[i];
      dovf[i] = |dmag[i][DW-1:DIST_W];
    end
  end

  logic              s3_v_r, s3_m_r, s3_l_r, s3_o_r;
  logic [DIST_W-1:0] s3_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
    if (en) begin
      s3_m_r <= s2_m_r;
      s3_l_r <= s2_l_r;
      s3_o_r <= |dovf;
      for (int i = 0; i < 3; i++) s3_mag_r[i] <= dmag[i][DIST_W-1:0];
    end
  end

  // stage 4: squares
  logic           s4_v_r, s4_m_r, s4_l_r, s4_o_r;
  logic [SQW-1:0] s4_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
    if (en) begin
      s4_m_r <= s3_m_r;
      s4_l_r <= s3_l_r;
      s4_o_r <= s3_o_r;
      for (int i = 0; i < 3; i++) s4_sq_r[i] <= s3_mag_r[i] * s3_mag_r[i];
    end
  end

  // stage 5: sum of squares, saturate on overflow
  logic [SQW+1:0] sqsum;
  assign sqsum = {2'b00, s4_sq_r[0]} + {2'b00, s4_sq_r[1]} + {2'b00, s4_sq_r[2]};

  // square root stages, one result bit each
  logic              rt_v_r [NST+1];
  logic              rt_m_r [NST+1];
  logic              rt_l_r [NST+1];
  logic              rt_s_r [NST+1];
  logic [SQW-1:0]    rt_n_r [NST+1];
  logic [RW-1:0]     rt_r_r [NST+1];
  logic [DIST_W-1:0] rt_q_r [NST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (en) begin
      rt_v_r[0] <= s4_v_r;
    end
    if (en) begin
      rt_m_r[0] <= s4_m_r;
      rt_l_r[0] <= s4_l_r;
      rt_s_r[0] <= s4_o_r || (|sqsum[SQW+1:SQW]);
      rt_n_r[0] <= sqsum[SQW-1:0];
      rt_r_r[0] <= '0;
      rt_q_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_root
    logic [RW-1:0] r_sh;
    logic [RW-1:0] trial;
    logic          ge;

    assign r_sh  = {rt_r_r[k][RW-3:0], rt_n_r[k][SQW-1:SQW-2]};
    assign trial = {2'b00, rt_q_r[k], 2'b01};
    assign ge    = r_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k+1] <= 1'b0;
      end else if (en) begin
        rt_v_r[k+1] <= rt_v_r[k];
      end
      if (en) begin
        rt_m_r[k+1] <= rt_m_r[k];
        rt_l_r[k+1] <= rt_l_r[k];
        rt_s_r[k+1] <= rt_s_r[k];
        rt_n_r[k+1] <= {rt_n_r[k][SQW-3:0], 2'b00};
        rt_r_r[k+1] <= ge ? (r_sh - trial) : r_sh;
        rt_q_r[k+1] <= {rt_q_r[k][DIST_W-2:0], ge};
      end
    end
  end

  assign q_wr            = en && rt_v_r[NST];
  assign q_item.distance = rt_s_r[NST] ? {DIST_W{1'b1}} : rt_q_r[NST];
  assign q_item.matched  = rt_m_r[NST];
  assign q_item.last     = rt_l_r[NST];

endmodule

// ----- hdl/lamd_fifo.sv -----
module lamd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  lamd_pkg::lamd_item_t wdata,
  output logic                 full,
  input  logic                 rd,
  output lamd_pkg::lamd_item_t rdata,
  output logic                 empty
);
  import lamd_pkg::*;

  lamd_item_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = cnt_r == QDEPTH[QPTR_W:0];
  assign empty = cnt_r == '0;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (wr) mem[wp_r] <= wdata;
  end

endmodule

// ----- hdl/lamd_back.sv -----
module lamd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lamd_pkg::lamd_item_t        q_item,
  output logic                        q_rd,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [lamd_pkg::DIST_W-1:0] out_mean_distance,
  output logic [lamd_pkg::CNT_W-1:0]  out_matched_count,
  output lamd_pkg::lamd_back_stat_t   stat
);
  import lamd_pkg::*;

  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 dv_busy_r;
  logic [DIV_CNT_W-1:0] dv_step_r;
  logic [SUM_W-1:0]     dv_quo_r;
  logic [CNT_W-1:0]     dv_rem_r;
  logic [CNT_W-1:0]     dv_den_r;
  logic [CNT_W-1:0]     dv_cnt_r;
  logic                 res_v_r;
  logic [DIST_W-1:0]    res_mean_r;
  logic [CNT_W-1:0]     res_cnt_r;

  logic [SUM_W:0]       sum_wide;
  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 dv_run, dv_done;
  logic [CNT_W:0]       rem_sh, rem_diff;
  logic                 rem_ge;

  // a last request waits until the divider is free
  assign q_rd = !q_empty && (!q_item.last || !dv_busy_r);

  always_comb begin
    sum_wide = {1'b0, sum_r} + {{(SUM_W+1-DIST_W){1'b0}}, q_item.distance};
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    if (q_item.matched) begin
      sum_nxt = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
    end
  end

  assign dv_run   = dv_busy_r && (dv_step_r != SUM_W[DIV_CNT_W-1:0]);
  assign dv_done  = dv_busy_r && (dv_step_r == SUM_W[DIV_CNT_W-1:0]);
  assign rem_sh   = {dv_rem_r, dv_quo_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dv_den_r};
  assign rem_ge   = rem_sh >= {1'b0, dv_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      cnt_r     <= '0;
      dv_busy_r <= 1'b0;
      dv_step_r <= '0;
      res_v_r   <= 1'b0;
    end else begin
      if (q_rd) begin
        if (q_item.last) begin
          sum_r     <= '0;
          cnt_r     <= '0;
          dv_busy_r <= 1'b1;
          dv_step_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (dv_run) dv_step_r <= dv_step_r + 1'b1;
      if (dv_done && !res_v_r) begin
        dv_busy_r <= 1'b0;
        res_v_r   <= 1'b1;
      end else if (out_pop && res_v_r) begin
        res_v_r <= 1'b0;
      end
    end
    // divider datapath
    if (q_rd && q_item.last) begin
      dv_quo_r <= sum_nxt;
      dv_rem_r <= '0;
      dv_den_r <= (cnt_nxt == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : cnt_nxt;
      dv_cnt_r <= cnt_nxt;
    end else if (dv_run) begin
      dv_quo_r <= {dv_quo_r[SUM_W-2:0], rem_ge};
      dv_rem_r <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (dv_done && !res_v_r) begin
      res_mean_r <= (|dv_quo_r[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : dv_quo_r[DIST_W-1:0];
      res_cnt_r  <= dv_cnt_r;
    end
  end

  assign out_empty         = !res_v_r;
  assign out_mean_distance = res_mean_r;
  assign out_matched_count = res_cnt_r;
  assign stat.div_busy     = dv_busy_r;
  assign stat.pop_last     = q_rd && q_item.last;

endmodule

// ----- hdl/label_affine_mean_displacement.sv -----
// Label affine mean displacement.
// Input queue port: present one voxel per request (label, x/y/z, last flag) with
// in_push; it is taken on a clock edge where in_push is high and in_full is low.
// Voxels whose label equals the target label are mapped through the 3x4 matrix
// and the Euclidean distance to their own position is summed; the request marked
// last closes the volume. Result queue port: while out_empty is low the mean
// distance (unsigned Q16.16) and the match count are on out_*; pop with out_pop.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (rows 0..5, then the target label); cfg_ready is always high. Write only idle.
// Throughput: one voxel per cycle while in_full is low; the front pipeline holds
// one multiplier per product term and one root bit per stage.
// Path: the front holds 5 arithmetic stages and 32 root stages ahead of the
// queue; the serial divider turns the volume sum into the mean once the last
// voxel is read from the queue. The next volume streams
// in while the divide runs; a second last voxel waits for the divider.
// Reset (synchronous, rst_n low): clears the configuration registers, sums and
// counts to zero, empties all stages and the queue. When the receiver stalls,
// the result is held, the divider and then the queue fill, and in_full rises to hold off the sender.
`include "label_affine_mean_displacement_macros.svh"

module label_affine_mean_displacement #(
  parameter int COORD_BITS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // voxel request channel
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [lamd_pkg::LABEL_W-1:0]   in_voxel_value,
  input  logic [COORD_BITS-1:0]          in_coord_x,
  input  logic [COORD_BITS-1:0]          in_coord_y,
  input  logic [COORD_BITS-1:0]          in_coord_z,
  input  logic                           in_last_voxel,
  // result channel
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [lamd_pkg::DIST_W-1:0]    out_mean_distance,
  output logic [lamd_pkg::CNT_W-1:0]     out_matched_count,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lamd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lamd_pkg::WORD_W-1:0]    cfg_data
);
  import lamd_pkg::*;

  coef_bank_t        rows_r;
  logic [LABEL_W-1:0] target_r;

  assign cfg_ready = 1'b1;

  // register file: six matrix words and the target label; drop other indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= '0;
      target_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW0_LO, REG_ROW0_HI, REG_ROW1_LO,
        REG_ROW1_HI, REG_ROW2_LO, REG_ROW2_HI: rows_r[cfg_index] <= cfg_data;
        REG_TARGET: target_r <= cfg_data[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic            q_wr, q_full, q_rd, q_empty;
  lamd_item_t      q_wdata, q_rdata;
  lamd_back_stat_t back_stat;

  // front: match, transform, distance
  lamd_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef           (rows_r),
    .target_label   (target_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_voxel_value (in_voxel_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_last_voxel  (in_last_voxel),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_item         (q_wdata)
  );

  // short queue parting front and back
  lamd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: accumulate, divide, hold result
  lamd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (q_rdata),
    .q_rd              (q_rd),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_mean_distance (out_mean_distance),
    .out_matched_count (out_matched_count),
    .stat              (back_stat)
  );

  `LAMD_ASSERT_IMPLY(a_q_no_overflow, clk, rst_n, q_wr, !q_full)
  `LAMD_ASSERT_IMPLY(a_last_div_free, clk, rst_n, back_stat.pop_last, !back_stat.div_busy)
  `LAMD_ASSERT_NEXT(a_div_starts, clk, rst_n, back_stat.pop_last, back_stat.div_busy)
  `LAMD_ASSERT_IMPLY(a_zero_count_mean, clk, rst_n, !out_empty && out_matched_count == '0, out_mean_distance == '0)

endmodule

// ----- tb/sv/tb_label_affine_mean_displacement.sv -----
module tb_label_affine_mean_displacement;
  import lamd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 8;
  localparam int FRAC_BITS  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;  // no register behind it
  localparam int MAX_IDLE   = 18;
  localparam int LONG_HOLD  = 1500;
  localparam int DRAIN_WAIT = 150;   // beyond the front plus divide latency
  localparam longint unsigned W32_MAX = 64'hFFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [LABEL_W-1:0]    label;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic                  last;
  } voxel_t;

  typedef struct packed {
    logic [DIST_W-1:0] mean;
    logic [CNT_W-1:0]  count;
  } volume_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [LABEL_W-1:0]    in_voxel_value = '0;
  logic [COORD_BITS-1:0] in_coord_x = '0;
  logic [COORD_BITS-1:0] in_coord_y = '0;
  logic [COORD_BITS-1:0] in_coord_z = '0;
  logic                  in_last_voxel = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [DIST_W-1:0]     out_mean_distance;
  logic [CNT_W-1:0]      out_matched_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [WORD_W-1:0]     cfg_data = '0;

  label_affine_mean_displacement #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (.*);

  // Pending voxels, expected volume results and the shadow of the registers
  voxel_t          voxel_q[$];
  volume_result_t  result_q[$];
  logic [WORD_W-1:0]  matrix_shadow[ROW_REGS];
  logic [LABEL_W-1:0] label_shadow;
  logic [SUM_W-1:0]   dist_sum;
  logic [CNT_W-1:0]   match_cnt;

  int  error_count = 0;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b0;
  int  hold_asked = 0;
  int  hold_granted = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  rx_hold = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Coefficient k of matrix row r (k = 3 is the translation), sign-extended
  function automatic longint coef(int r, int k);
    logic [WORD_W-1:0] w;
    logic [COEF_W-1:0] part;
    w = matrix_shadow[2 * r + k / 2];
    part = (k % 2) ? w[63:32] : w[31:0];
    return longint'(signed'(part));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Distance of one voxel from its mapped position, Q16.16, saturated
  function automatic longint unsigned displacement(voxel_t v);
    longint c[3];
    longint p;
    longint d;
    longint unsigned mag;
    logic [64:0] acc;
    c[0] = longint'(v.x);
    c[1] = longint'(v.y);
    c[2] = longint'(v.z);
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      p = coef(i, 0) * c[0] + coef(i, 1) * c[1] + coef(i, 2) * c[2] + coef(i, 3);
      d = (c[i] <<< FRAC_BITS) - p;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      if (mag > W32_MAX) return W32_MAX;
      acc = acc + {1'b0, mag * mag};
      if (acc[64]) return W32_MAX;
    end
    return int_sqrt(acc[63:0]);
  endfunction

  // Fold one accepted voxel into the running volume; queue the result on last
  function automatic void account_voxel(voxel_t v);
    longint unsigned vox_dist;
    logic [SUM_W:0] widened;
    logic [SUM_W-1:0] q;
    volume_result_t res;
    if (v.label == label_shadow) begin
      vox_dist = displacement(v);
      widened = {1'b0, dist_sum} + (SUM_W+1)'(vox_dist);
      dist_sum = widened[SUM_W] ? SUM_MAX : widened[SUM_W-1:0];
      if (match_cnt != CNT_MAX) match_cnt++;
    end
    if (v.last) begin
      q = dist_sum / ((match_cnt == 0) ? 1 : match_cnt);
      res.mean = (q > W32_MAX) ? DIST_W'(W32_MAX) : q[DIST_W-1:0];
      res.count = match_cnt;
      result_q.push_back(res);
      dist_sum = '0;
      match_cnt = '0;
    end
  endfunction

  // Shadow every register write as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROW_REGS; i++) matrix_shadow[i] <= '0;
      label_shadow <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TARGET) label_shadow <= cfg_data[LABEL_W-1:0];
      else if (cfg_index < ROW_REGS) matrix_shadow[cfg_index] <= cfg_data;
    end
  end

  // Driver: predict on each accepted request, then offer the next one
  always @(posedge clk) begin
    voxel_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
      tx_gap <= 0;
      dist_sum = '0;
      match_cnt = '0;
    end else begin
      if (in_push && !in_full)
        account_voxel({in_voxel_value, in_coord_x, in_coord_y, in_coord_z, in_last_voxel});
      // hold the request steady while the block is full
      if (!in_push || !in_full) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_push <= 1'b0;
        end else if (voxel_q.size() > 0) begin
          nxt = voxel_q.pop_front();
          in_voxel_value <= nxt.label;
          in_coord_x <= nxt.x;
          in_coord_y <= nxt.y;
          in_coord_z <= nxt.z;
          in_last_voxel <= nxt.last;
          in_push <= 1'b1;
          tx_gap <= tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    volume_result_t want;
    int wait_n;
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_stall <= 0;
      rx_hold <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: mean_distance %0h matched_count %0d",
                 out_mean_distance, out_matched_count);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (out_mean_distance !== want.mean) begin
            $error("mean_distance: expected %0h, got %0h", want.mean, out_mean_distance);
            error_count++;
          end
          if (out_matched_count !== want.count) begin
            $error("matched_count: expected %0d, got %0d", want.count, out_matched_count);
            error_count++;
          end
        end
      end
      if (hold_granted != hold_asked) begin
        // long stall: let the block back up into its input
        hold_granted <= hold_asked;
        rx_hold <= LONG_HOLD;
        out_pop <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_pop <= 1'b0;
      end else if (out_pop && !out_empty) begin
        wait_n = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        rx_stall <= wait_n;
        out_pop <= (wait_n == 0);
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_finish();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every request to go in and every result to come out
  task automatic drain();
    do @(posedge clk); while (voxel_q.size() > 0 || in_push || result_q.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void add_voxel(logic [7:0] lab, logic [7:0] x, logic [7:0] y,
                                    logic [7:0] z, logic last);
    voxel_q.push_back({lab, x, y, z, last});
  endfunction

  function automatic logic [31:0] q16(int value);
    return 32'(value) << FRAC_BITS;
  endfunction

  // Random matrix: either close to identity or raw random words
  task automatic load_matrix(bit wild);
    logic [COEF_W-1:0] m[4];
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        if (wild) m[k] = $urandom;
        else if (k == 3) m[k] = 32'($urandom_range(0, 40 << FRAC_BITS)) - q16(20);
        else if (k == r) m[k] = q16(1) + $urandom_range(0, 16'h3FFF) - 32'h2000;
        else m[k] = 32'($urandom_range(0, 16'h0FFF)) - 32'h0800;
      end
      cfg_write(cfg_reg_t'(2 * r), {m[1], m[0]});
      cfg_write(cfg_reg_t'(2 * r + 1), {m[3], m[2]});
    end
  endtask

  // Random volumes: mostly voxels of the target label, each volume closed by last
  task automatic add_volumes(int n, logic [7:0] lab);
    int left;
    left = n;
    while (left > 0) begin
      left--;
      add_voxel(($urandom_range(0, 9) < 6) ? lab : 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom),
                (left == 0) || ($urandom_range(0, 11) == 0));
    end
  endtask

  initial begin
    logic [7:0] lab;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero matrix, target 0: distance is the voxel's own radius
    add_voxel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    add_voxel(8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
    add_voxel(8'd5, 8'd9, 8'd1, 8'd2, 1'b1);          // no match in volume
    add_voxel(8'd0, 8'd3, 8'd4, 8'd0, 1'b0);
    add_voxel(8'd7, 8'd255, 8'd0, 8'd1, 1'b0);
    add_voxel(8'd0, 8'd0, 8'd255, 8'd128, 1'b1);
    drain();

    // Identity plus translation (3, 4, 0): every match sits 5 voxels away
    cfg_write(REG_ROW0_LO, {32'd0, q16(1)});
    cfg_write(REG_ROW0_HI, {q16(3), 32'd0});
    cfg_write(REG_ROW1_LO, {q16(1), 32'd0});
    cfg_write(REG_ROW1_HI, {q16(4), 32'd0});
    cfg_write(REG_ROW2_LO, 64'd0);
    cfg_write(REG_ROW2_HI, {32'd0, q16(1)});
    cfg_write(REG_TARGET, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(CFG_SPARE_IDX, 64'h5A5A_A5A5_0F0F_F0F0);  // must be dropped
    cfg_finish();
    add_voxel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    add_voxel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    add_voxel(8'd254, 8'd17, 8'd33, 8'd65, 1'b1);
    add_voxel(8'd0, 8'd1, 8'd1, 8'd1, 1'b1);
    drain();

    // Largest positive coefficients: the displacement of the far voxel saturates
    for (int i = 0; i < ROW_REGS; i++) cfg_write(cfg_reg_t'(i), 64'h7FFF_FFFF_7FFF_FFFF);
    cfg_write(REG_TARGET, 64'd0);
    cfg_finish();
    add_voxel(8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    add_voxel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    drain();

    // Most negative and all-ones coefficients
    for (int i = 0; i < ROW_REGS; i++) cfg_write(cfg_reg_t'(i), 64'h8000_0000_8000_0000);
    cfg_finish();
    add_voxel(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
    add_voxel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    drain();
    for (int i = 0; i < ROW_REGS; i++) cfg_write(cfg_reg_t'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_finish();
    add_voxel(8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    add_voxel(8'd0, 8'd128, 8'd64, 8'd1, 1'b1);
    drain();

    // Random phases; idling on both sides in some, on one side only in others
    for (int ph = 0; ph < 8; ph++) begin
      lab = 8'($urandom);
      load_matrix(ph % 3 == 2);
      cfg_write(REG_TARGET, {$urandom, $urandom});
      cfg_finish();
      lab = label_shadow;
      tx_idle = (ph % 4) != 1;
      rx_idle = (ph % 4) != 2;
      if (ph == 5) begin
        // receiver stalls while single-voxel volumes keep coming
        hold_asked++;
        tx_idle = 1'b0;
        repeat (40) add_voxel(lab, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      end
      add_volumes(50, lab);
      drain();
    end

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
